[hdl/tadc_pkg.sv]
// ----------------------------------------------------------------------------
// tadc_pkg
// Shared widths, register reset values, codes and types for the thermistor
// ADC code to temperature converter.
// ----------------------------------------------------------------------------
package tadc_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int RES_W        = 24;   // resistance, unsigned Q8.16
	localparam int COEF_W       = 48;   // coefficients, signed Q16.32
	localparam int TEMP_W       = 16;   // temperature, signed Q8.8
	localparam int STAT_W       = 2;
	localparam int CIDX_W       = 3;
	localparam int NCOEF        = 7;
	localparam int NSTEP        = NCOEF - 1;
	localparam int PROD_W       = 58;   // signed product plus coefficient headroom

	// status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_FIXED_RES = 3'd0;
	localparam logic [CIDX_W-1:0] REG_COEF_SIX  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_COEF_FIVE = 3'd2;
	localparam logic [CIDX_W-1:0] REG_COEF_FOUR = 3'd3;
	localparam logic [CIDX_W-1:0] REG_COEF_THR  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_COEF_TWO  = 3'd5;
	localparam logic [CIDX_W-1:0] REG_COEF_ONE  = 3'd6;
	localparam logic [CIDX_W-1:0] REG_COEF_ZERO = 3'd7;

	// register reset values
	localparam logic [RES_W-1:0]         FIXED_RES_RST = 24'd786432;
	localparam logic signed [COEF_W-1:0] COEF_SIX_RST  = -48'sd297034;
	localparam logic signed [COEF_W-1:0] COEF_FIVE_RST = 48'sd22263600;
	localparam logic signed [COEF_W-1:0] COEF_FOUR_RST = -48'sd683545816;
	localparam logic signed [COEF_W-1:0] COEF_THR_RST  = 48'sd10941893995;
	localparam logic signed [COEF_W-1:0] COEF_TWO_RST  = -48'sd95259896098;
	localparam logic signed [COEF_W-1:0] COEF_ONE_RST  = 48'sd412040468745;
	localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = -48'sd522856746143;

	localparam logic signed [COEF_W-1:0] ACC_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] ACC_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

	// queue fill state seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hdl/tadc_front.sv]
// ----------------------------------------------------------------------------
// tadc_front
// Accepts ADC codes, flags the zero code and forms the divider numerator
// fixed_resistance * (full scale - code).
// ----------------------------------------------------------------------------
module tadc_front import tadc_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF,
	localparam int NUM_W = RES_W + ADC_BITS,
	localparam int ENT_W = 1 + ADC_BITS + NUM_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ADC_BITS-1:0] adc_code,
	input  logic [RES_W-1:0]    fixed_res,
	input  q_stat_t             qstat,
	output logic                busy,
	output logic                push,
	output logic [ENT_W-1:0]    push_data
);

	logic                v_s1;
	logic                zero_s1;
	logic [ADC_BITS-1:0] code_s1;
	logic [NUM_W-1:0]    num_s1;
	logic                accept;
	logic [ADC_BITS-1:0] diff;

	assign busy   = qstat.full;
	assign accept = start && !busy;
	assign diff   = {ADC_BITS{1'b1}} - adc_code;

	// request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// classify and multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			zero_s1 <= (adc_code == '0);
			code_s1 <= adc_code;
			num_s1  <= NUM_W'(fixed_res) * NUM_W'(diff);
		end
	end

	assign push      = v_s1;
	assign push_data = {zero_s1, code_s1, num_s1};

endmodule

[hdl/tadc_queue.sv]
// ----------------------------------------------------------------------------
// tadc_queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module tadc_queue import tadc_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output q_stat_t          qstat
);

	logic [WIDTH-1:0] mem_q [0:1];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             do_pop;
	logic             do_push;

	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full  = (cnt_q == 2'd2);
	assign do_pop      = pop && !qstat.empty;
	assign do_push     = push && !qstat.full;
	assign head        = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

[hdl/tadc_div.sv]
// ----------------------------------------------------------------------------
// tadc_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the quotient to the resistance width.
// ----------------------------------------------------------------------------
module tadc_div import tadc_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF,
	localparam int NUM_W = RES_W + ADC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_zero,
	input  logic [ADC_BITS-1:0] in_code,
	input  logic [NUM_W-1:0]    in_num,
	output logic                out_valid,
	output logic                out_zero,
	output logic [RES_W-1:0]    out_res
);

	logic                v_s  [0:NUM_W];
	logic                z_s  [0:NUM_W];
	logic [ADC_BITS-1:0] d_s  [0:NUM_W];
	logic [ADC_BITS-1:0] rm_s [0:NUM_W];
	logic [NUM_W-1:0]    nq_s [0:NUM_W];

	assign v_s[0]  = in_valid;
	assign z_s[0]  = in_zero;
	assign d_s[0]  = in_code;
	assign rm_s[0] = '0;
	assign nq_s[0] = in_num;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [ADC_BITS:0] trial;
		logic [ADC_BITS:0] diff;
		logic              ge;

		// shift in next numerator bit, subtract if it fits
		assign trial = {rm_s[i], nq_s[i][NUM_W-1]};
		assign ge    = (trial >= {1'b0, d_s[i]});
		assign diff  = trial - {1'b0, d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			z_s[i+1]  <= z_s[i];
			d_s[i+1]  <= d_s[i];
			rm_s[i+1] <= ge ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
			nq_s[i+1] <= {nq_s[i][NUM_W-2:0], ge};
		end
	end

	// saturate; zero code reads as full scale
	assign out_valid = v_s[NUM_W];
	assign out_zero  = z_s[NUM_W];
	assign out_res   = (z_s[NUM_W] || (nq_s[NUM_W][NUM_W-1:RES_W] != '0))
		? {RES_W{1'b1}} : nq_s[NUM_W][RES_W-1:0];

endmodule

[hdl/tadc_horner.sv]
// ----------------------------------------------------------------------------
// tadc_horner
// Six Horner steps of four stages each (magnitude, partial products,
// rounding and sign, coefficient add and clamp), then Q8.8 output register.
// ----------------------------------------------------------------------------
module tadc_horner import tadc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_zero,
	input  logic [RES_W-1:0]         in_res,
	input  logic signed [COEF_W-1:0] coef [0:NCOEF-1],
	output logic                     done,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [RES_W-1:0]         resistance,
	output logic [STAT_W-1:0]        status
);

	// step inputs; index NSTEP is the chain result
	logic                     sv  [0:NSTEP];
	logic                     sz  [0:NSTEP];
	logic                     ss  [0:NSTEP];
	logic [RES_W-1:0]         sr  [0:NSTEP];
	logic signed [COEF_W-1:0] sa  [0:NSTEP];

	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [RES_W-1:0]         res_q;
	logic [STAT_W-1:0]        stat_q;
	logic signed [RES_W-1:0]  t_wide;

	assign sv[0] = in_valid;
	assign sz[0] = in_zero;
	assign ss[0] = 1'b0;
	assign sr[0] = in_res;
	assign sa[0] = coef[0];

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic                     v_s1, v_s2, v_s3, v_s4;
		logic                     z_s1, z_s2, z_s3;
		logic                     st_s1, st_s2, st_s3;
		logic [RES_W-1:0]         r_s1, r_s2, r_s3;
		logic                     neg_s1, neg_s2;
		logic [COEF_W-1:0]        mag_s1;
		logic [2*RES_W-1:0]       phi_s2, plo_s2;
		logic signed [PROD_W-1:0] prod_s3;
		logic [PROD_W-3:0]        q;
		logic [PROD_W-3:0]        q1;
		logic signed [PROD_W-1:0] sum;
		logic                     hi_clip, lo_clip;

		// valid chain
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				v_s4 <= 1'b0;
			end else begin
				v_s1 <= sv[k];
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end

		// truncation toward minus infinity of the signed product
		assign q   = {phi_s2, 8'b0} + (PROD_W-2)'(plo_s2[2*RES_W-1:16]);
		assign q1  = q + (PROD_W-2)'(plo_s2[15:0] != '0);
		assign sum = prod_s3 + PROD_W'(coef[k+1]);
		assign hi_clip = (sum > PROD_W'(ACC_MAX));
		assign lo_clip = (sum < PROD_W'(ACC_MIN));

		always_ff @(posedge clk) begin
			// stage 1: magnitude
			neg_s1 <= sa[k][COEF_W-1];
			mag_s1 <= sa[k][COEF_W-1] ? COEF_W'(-sa[k]) : COEF_W'(sa[k]);
			z_s1   <= sz[k];
			st_s1  <= ss[k];
			r_s1   <= sr[k];
			// stage 2: two 24x24 partial products
			phi_s2 <= (2*RES_W)'(mag_s1[COEF_W-1:RES_W]) * (2*RES_W)'(r_s1);
			plo_s2 <= (2*RES_W)'(mag_s1[RES_W-1:0]) * (2*RES_W)'(r_s1);
			neg_s2 <= neg_s1;
			z_s2   <= z_s1;
			st_s2  <= st_s1;
			r_s2   <= r_s1;
			// stage 3: recombine and apply sign; round up only when negative
			prod_s3 <= neg_s2 ? -PROD_W'(q1) : PROD_W'(q);
			z_s3    <= z_s2;
			st_s3   <= st_s2;
			r_s3    <= r_s2;
			// stage 4: add coefficient, clamp to 48 bits
			if (hi_clip) begin
				sa[k+1] <= ACC_MAX;
			end else if (lo_clip) begin
				sa[k+1] <= ACC_MIN;
			end else begin
				sa[k+1] <= sum[COEF_W-1:0];
			end
			ss[k+1] <= st_s3 || hi_clip || lo_clip;
			sz[k+1] <= z_s3;
			sr[k+1] <= r_s3;
		end

		assign sv[k+1] = v_s4;
	end

	// floor divide by 2^24, clamp to Q8.8
	assign t_wide = sa[NSTEP][COEF_W-1:COEF_W-RES_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sv[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= sr[NSTEP];
		if (sz[NSTEP]) begin
			temp_q <= TEMP_MAX;
			stat_q <= ST_ZERO;
		end else if (t_wide > RES_W'(TEMP_MAX)) begin
			temp_q <= TEMP_MAX;
			stat_q <= ST_SAT;
		end else if (t_wide < RES_W'(TEMP_MIN)) begin
			temp_q <= TEMP_MIN;
			stat_q <= ST_SAT;
		end else begin
			temp_q <= t_wide[TEMP_W-1:0];
			stat_q <= ss[NSTEP] ? ST_SAT : ST_OK;
		end
	end

	assign done        = done_q;
	assign temperature = temp_q;
	assign resistance  = res_q;
	assign status      = stat_q;

endmodule

[hdl/thermistor_adc_to_temperature_top.sv]
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_top
// Thermistor divider ADC code to resistance and Q8.8 Celsius temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive adc_code and raise start; the code is taken at a rising edge
//   where start is high and busy is low. busy rises only if the two-entry
//   queue between front end and back end is full.
//   Output: done is high for one cycle with temperature, resistance and
//   status; the receiver cannot hold it off and the back end never stalls.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no conversion is in flight.
// Throughput: one code per cycle, continuously.
// Pipeline: the front-end register, the queue, the one-bit-per-stage divider
//   (24 + ADC_BITS stages), the six four-stage Horner steps and the output
//   register lie between acceptance and done.
// Reset: all in-flight requests are dropped, registers return to the
//   thermistor curve defaults (12 kOhm fixed resistor).
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_top import tadc_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ADC_BITS-1:0]      adc_code,
	output logic                     done,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [RES_W-1:0]         resistance,
	output logic [STAT_W-1:0]        status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [COEF_W-1:0]        cfg_data
);

	localparam int NUM_W = RES_W + ADC_BITS;
	localparam int ENT_W = 1 + ADC_BITS + NUM_W;

	logic [RES_W-1:0]         fixed_res_q;
	logic signed [COEF_W-1:0] coef_q [0:NCOEF-1];
	q_stat_t                  qstat;
	logic                     push;
	logic [ENT_W-1:0]         push_data;
	logic [ENT_W-1:0]         head;
	logic                     dv;
	logic                     dz;
	logic [RES_W-1:0]         dres;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_res_q <= FIXED_RES_RST;
			coef_q[0]   <= COEF_SIX_RST;
			coef_q[1]   <= COEF_FIVE_RST;
			coef_q[2]   <= COEF_FOUR_RST;
			coef_q[3]   <= COEF_THR_RST;
			coef_q[4]   <= COEF_TWO_RST;
			coef_q[5]   <= COEF_ONE_RST;
			coef_q[6]   <= COEF_ZERO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIXED_RES: fixed_res_q <= cfg_data[RES_W-1:0];
				REG_COEF_SIX:  coef_q[0] <= cfg_data;
				REG_COEF_FIVE: coef_q[1] <= cfg_data;
				REG_COEF_FOUR: coef_q[2] <= cfg_data;
				REG_COEF_THR:  coef_q[3] <= cfg_data;
				REG_COEF_TWO:  coef_q[4] <= cfg_data;
				REG_COEF_ONE:  coef_q[5] <= cfg_data;
				REG_COEF_ZERO: coef_q[6] <= cfg_data;
				default: ;
			endcase
		end
	end

	tadc_front #(.ADC_BITS(ADC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.adc_code  (adc_code),
		.fixed_res (fixed_res_q),
		.qstat     (qstat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// back end never stalls, so the head is taken whenever present
	tadc_queue #(.WIDTH(ENT_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (!qstat.empty),
		.head      (head),
		.qstat     (qstat)
	);

	tadc_div #(.ADC_BITS(ADC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!qstat.empty),
		.in_zero   (head[ENT_W-1]),
		.in_code   (head[NUM_W +: ADC_BITS]),
		.in_num    (head[NUM_W-1:0]),
		.out_valid (dv),
		.out_zero  (dz),
		.out_res   (dres)
	);

	tadc_horner u_horner (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (dv),
		.in_zero     (dz),
		.in_res      (dres),
		.coef        (coef_q),
		.done        (done),
		.temperature (temperature),
		.resistance  (resistance),
		.status      (status)
	);

	// zero code always reports the saturated pair
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ZERO) |-> (temperature == TEMP_MAX
			&& resistance == {RES_W{1'b1}}))
		else $error("zero code result not saturated");

	// status is one of the defined codes
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_ZERO || status == ST_SAT))
		else $error("undefined status code");

	// an accepted code reaches the queue on the next edge
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> push)
		else $error("accepted request not pushed");

	// queue cannot fill while the back end drains every cycle
	a_no_full: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.full)
		else $error("queue filled");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the thermistor ADC code to temperature converter against a
// behavioural predictor. Codes are sent through the start/busy handshake and
// results are compared on each done strobe, in order. The coefficient and
// resistor registers go through the reset values, the extremes and random
// settings. The sender's idling changes from one phase to the next.
// ----------------------------------------------------------------------------
module testbench;
	import tadc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [11:0] FULL_CODE = 12'hFFF;
	localparam int          DRAIN_CYC = 80;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [RES_W-1:0]         res;
		logic [STAT_W-1:0]        stat;
	} reading_t;

	typedef struct {
		logic [11:0] code;
		bit          typed;
		reading_t    want;
	} vec_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [11:0]              adc_code;
	logic                     done;
	logic signed [TEMP_W-1:0] temperature;
	logic [RES_W-1:0]         resistance;
	logic [STAT_W-1:0]        status;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CIDX_W-1:0]        cfg_index;
	logic [COEF_W-1:0]        cfg_data;

	// shadow copy of the configuration registers
	logic [RES_W-1:0]         fixed_res;
	logic signed [COEF_W-1:0] coef [0:NCOEF-1];

	reading_t readings_due [$];
	bit       failed;
	int       idle_pct;

	thermistor_adc_to_temperature_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.adc_code    (adc_code),
		.done        (done),
		.temperature (temperature),
		.resistance  (resistance),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// divider then Horner chain, clamping as the block does
	function automatic reading_t convert(input logic [11:0] code);
		reading_t          r;
		logic [63:0]       quot;
		logic signed [127:0] acc;
		logic signed [127:0] t;
		r.stat = ST_OK;
		if (code == 12'd0) begin
			r.temp = TEMP_MAX;
			r.res  = {RES_W{1'b1}};
			r.stat = ST_ZERO;
			return r;
		end
		quot = (64'(fixed_res) * 64'(FULL_CODE - code)) / 64'(code);
		r.res = (quot > 64'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
		acc = coef[0];
		for (int k = 1; k < NCOEF; k++) begin
			acc = ((acc * $signed({104'd0, r.res})) >>> 16) + coef[k];
			if (acc > ACC_MAX) begin
				acc = ACC_MAX;
				r.stat = ST_SAT;
			end
			if (acc < ACC_MIN) begin
				acc = ACC_MIN;
				r.stat = ST_SAT;
			end
		end
		t = acc >>> 24;
		if (t > TEMP_MAX) begin
			t = TEMP_MAX;
			r.stat = ST_SAT;
		end
		if (t < TEMP_MIN) begin
			t = TEMP_MIN;
			r.stat = ST_SAT;
		end
		r.temp = t[15:0];
		return r;
	endfunction

	// one register write, shadow updated on acceptance; the caller drops valid
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FIXED_RES)
			fixed_res = val[RES_W-1:0];
		else
			coef[idx - 1] = val;
	endtask

	task automatic write_all(input logic [RES_W-1:0] fr, input logic [COEF_W-1:0] c [0:NCOEF-1]);
		write_reg(REG_FIXED_RES, {24'd0, fr});
		for (int k = 0; k < NCOEF; k++)
			write_reg(CIDX_W'(k + 1), c[k]);
		cfg_valid <= 1'b0;
	endtask

	// one request; the expectation is queued when the block takes it
	task automatic send_code(input logic [11:0] code, input bit typed, input reading_t want);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start    <= 1'b1;
		adc_code <= code;
		do @(posedge clk); while (busy);
		readings_due.push_back(typed ? want : convert(code));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	function automatic logic [11:0] rand_code;
		case ($urandom_range(7))
			0: rand_code = 12'd0;
			1: rand_code = 12'($urandom_range(1, 3));
			2: rand_code = FULL_CODE - 12'($urandom_range(2));
			default: rand_code = 12'($urandom_range(4095));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		reading_t w;
		if (arst_n && done) begin
			if (readings_due.size() == 0) begin
				$display("%0t: result with none due: temp %0d res %0h status %0d",
					$time, temperature, resistance, status);
				failed = 1'b1;
			end else begin
				w = readings_due.pop_front();
				if (temperature !== w.temp) begin
					$display("%0t: temperature expected %0d got %0d", $time, w.temp, temperature);
					failed = 1'b1;
				end
				if (resistance !== w.res) begin
					$display("%0t: resistance expected %0h got %0h", $time, w.res, resistance);
					failed = 1'b1;
				end
				if (status !== w.stat) begin
					$display("%0t: status expected %0d got %0d", $time, w.stat, status);
					failed = 1'b1;
				end
			end
		end
	end

	// stimulus
	initial begin
		vec_t                     dir [$];
		vec_t                     v;
		reading_t                 none;
		logic [COEF_W-1:0]        c [0:NCOEF-1];
		logic [RES_W-1:0]         fr;
		int                       n;
		failed    = 1'b0;
		idle_pct  = 16;
		arst_n    = 1'b0;
		start     = 1'b0;
		adc_code  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		none      = '{temp: '0, res: '0, stat: ST_OK};
		fixed_res = FIXED_RES_RST;
		coef[0] = COEF_SIX_RST;
		coef[1] = COEF_FIVE_RST;
		coef[2] = COEF_FOUR_RST;
		coef[3] = COEF_THR_RST;
		coef[4] = COEF_TWO_RST;
		coef[5] = COEF_ONE_RST;
		coef[6] = COEF_ZERO_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed codes at reset settings; zero code saturates outright
		dir.push_back('{12'd0, 1'b1, '{TEMP_MAX, 24'hFFFFFF, ST_ZERO}});
		v.typed = 1'b0;
		v.want  = none;
		for (int i = 0; i < 13; i++) begin
			case (i)
				0: v.code = 12'd1;    1: v.code = 12'd2;    2: v.code = 12'd3;
				3: v.code = 12'd4095; 4: v.code = 12'd4094; 5: v.code = 12'd2048;
				6: v.code = 12'd2047; 7: v.code = 12'hAAA;  8: v.code = 12'h555;
				9: v.code = 12'd1000; 10: v.code = 12'd3000; 11: v.code = 12'd200;
				default: v.code = 12'd3900;
			endcase
			dir.push_back(v);
		end
		foreach (dir[i])
			send_code(dir[i].code, dir[i].typed, dir[i].want);
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					fr = '0;
					foreach (c[k]) c[k] = ACC_MAX;
					n = 100;
					idle_pct = 16;
				end
				1: begin
					fr = 24'hFFFFFF;
					foreach (c[k]) c[k] = ACC_MIN;
					n = 100;
					idle_pct = 84;
				end
				2: begin
					fr = 24'($urandom);
					foreach (c[k]) c[k] = COEF_W'($signed(32'($urandom)));
					n = 350;
					idle_pct = 16;
				end
				3: begin
					fr = 24'($urandom_range(400000, 1400000));
					c[0] = COEF_SIX_RST;  c[1] = COEF_FIVE_RST; c[2] = COEF_FOUR_RST;
					c[3] = COEF_THR_RST;  c[4] = COEF_TWO_RST;  c[5] = COEF_ONE_RST;
					c[6] = COEF_ZERO_RST;
					n = 350;
					idle_pct = 84;
				end
				default: begin
					fr = 24'($urandom);
					foreach (c[k]) c[k] = {16'($urandom), 32'($urandom)};
					n = 350;
					idle_pct = 0;
				end
			endcase
			write_all(fr, c);
			for (int i = 0; i < n; i++)
				send_code(rand_code(), 1'b0, none);
			drain();
		end

		if (!failed)
			$display("thermistor_adc_to_temperature_top: match");
		else
			$display("thermistor_adc_to_temperature_top: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("thermistor_adc_to_temperature_top: mismatch");
		$finish;
	end

endmodule
